// ----- rtl/core/sbog_pkg.sv -----
// ----------------------------------------------------------------------------
// sbog_pkg
// shared types and constants of the strided batch offset generator
// ----------------------------------------------------------------------------
package sbog_pkg;

    localparam int MAX_DIMS_DEFAULT = 3;

    localparam int IDX_W      = 16;
    localparam int SIZE_W     = 16;
    localparam int STRIDE_W   = 32;
    localparam int PROD_W     = STRIDE_W + IDX_W;
    localparam int OFFSET_W   = 50;
    localparam int DCNT_W     = 2;
    localparam int OPK_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = ((OFFSET_W + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OP_KIND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_DIM0 = 3'd5;

    // operation kinds
    localparam logic [OPK_W-1:0] OP_OTHER  = 2'd0;
    localparam logic [OPK_W-1:0] OP_ARITH  = 2'd1;
    localparam logic [OPK_W-1:0] OP_MATMUL = 2'd2;

    typedef struct packed {
        logic last;
        logic empty;
    } sbog_flags_t;

endpackage

// ----- rtl/core/sbog_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sbog_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module sbog_cfg_regs #(
    parameter int MAX_DIMS = sbog_pkg::MAX_DIMS_DEFAULT
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 cfg_we,
    input  logic [sbog_pkg::CFG_IDX_W-1:0]                       cfg_index,
    input  logic [sbog_pkg::CFG_DATA_W-1:0]                      cfg_data,
    output logic [sbog_pkg::DCNT_W-1:0]                          dim_count,
    output logic [sbog_pkg::OPK_W-1:0]                           op_kind,
    output logic [MAX_DIMS-1:0][sbog_pkg::SIZE_W-1:0]            dim_size,
    output logic [MAX_DIMS-1:0][sbog_pkg::STRIDE_W-1:0]          dim_stride
);

    logic [sbog_pkg::DCNT_W-1:0]                 dim_count_reg;
    logic [sbog_pkg::OPK_W-1:0]                  op_kind_reg;
    logic [MAX_DIMS-1:0][sbog_pkg::SIZE_W-1:0]   size_reg;
    logic [MAX_DIMS-1:0][sbog_pkg::STRIDE_W-1:0] stride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg <= '0;
            op_kind_reg   <= sbog_pkg::OP_OTHER;
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                size_reg[d]   <= sbog_pkg::SIZE_W'(1);
                stride_reg[d] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == sbog_pkg::REG_DIM_COUNT)
            begin
                dim_count_reg <= cfg_data[sbog_pkg::DCNT_W-1:0];
            end
            if (cfg_index == sbog_pkg::REG_OP_KIND)
            begin
                op_kind_reg <= cfg_data[sbog_pkg::OPK_W-1:0];
            end
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                if (cfg_index == sbog_pkg::REG_SIZE_DIM0 + sbog_pkg::CFG_IDX_W'(d))
                begin
                    size_reg[d] <= cfg_data[sbog_pkg::SIZE_W-1:0];
                end
                if (cfg_index == sbog_pkg::REG_STRIDE_DIM0 + sbog_pkg::CFG_IDX_W'(d))
                begin
                    stride_reg[d] <= cfg_data[sbog_pkg::STRIDE_W-1:0];
                end
            end
        end
    end

    assign dim_count  = dim_count_reg;
    assign op_kind    = op_kind_reg;
    assign dim_size   = size_reg;
    assign dim_stride = stride_reg;

endmodule

// ----- rtl/core/sbog_odometer.sv -----
// ----------------------------------------------------------------------------
// sbog_odometer
// batch position counter, last batch dimension moves fastest
// ----------------------------------------------------------------------------
module sbog_odometer #(
    parameter int MAX_DIMS = sbog_pkg::MAX_DIMS_DEFAULT
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         advance,
    input  logic                                         restart,
    input  logic [sbog_pkg::DCNT_W-1:0]                  dim_count,
    input  logic [sbog_pkg::OPK_W-1:0]                   op_kind,
    input  logic [MAX_DIMS-1:0][sbog_pkg::SIZE_W-1:0]    dim_size,
    output logic [MAX_DIMS-1:0][sbog_pkg::IDX_W-1:0]     idx,
    output sbog_pkg::sbog_flags_t                        flags
);

    logic [MAX_DIMS-1:0][sbog_pkg::IDX_W-1:0] pos_reg;
    logic [MAX_DIMS-1:0][sbog_pkg::IDX_W-1:0] pos_next;
    logic [MAX_DIMS-1:0][sbog_pkg::IDX_W-1:0] eff;
    logic [MAX_DIMS-1:0]                      at_end;
    logic [MAX_DIMS-1:0]                      carry;
    logic [MAX_DIMS-1:0]                      in_batch;
    logic [sbog_pkg::DCNT_W-1:0]              used;
    logic [sbog_pkg::DCNT_W-1:0]              skip;
    logic [sbog_pkg::DCNT_W-1:0]              nb;
    logic                                     empty;
    logic [sbog_pkg::IDX_W:0]                 inc;

    // batch dimension count
    always_comb
    begin
        used = (32'(dim_count) > 32'(MAX_DIMS)) ? sbog_pkg::DCNT_W'(MAX_DIMS) : dim_count;
        case (op_kind)
            sbog_pkg::OP_MATMUL: skip = sbog_pkg::DCNT_W'(2);
            sbog_pkg::OP_ARITH:  skip = sbog_pkg::DCNT_W'(1);
            default:             skip = '0;
        endcase
        nb = (used >= skip) ? used - skip : '0;
    end

    always_comb
    begin
        empty = 1'b0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            in_batch[d] = (d < int'(nb));
            eff[d]      = (restart || !in_batch[d]) ? '0 : pos_reg[d];
            inc         = {1'b0, eff[d]} + (sbog_pkg::IDX_W+1)'(1);
            at_end[d]   = !in_batch[d] || (inc >= {1'b0, dim_size[d]});
            if (in_batch[d] && dim_size[d] == '0)
            begin
                empty = 1'b1;
            end
        end
        // carry into each dimension from all faster ones
        carry[MAX_DIMS-1] = 1'b1;
        for (int d = MAX_DIMS - 2; d >= 0; d--)
        begin
            carry[d] = carry[d+1] && at_end[d+1];
        end
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (empty || !in_batch[d])
            begin
                pos_next[d] = '0;
            end
            else if (carry[d])
            begin
                pos_next[d] = at_end[d] ? '0 : eff[d] + sbog_pkg::IDX_W'(1);
            end
            else
            begin
                pos_next[d] = eff[d];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (advance)
        begin
            pos_reg <= pos_next;
        end
    end

    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            idx[d] = empty ? '0 : eff[d];
        end
        flags.empty = empty;
        flags.last  = empty || (carry[0] && at_end[0]);
    end

endmodule

// ----- rtl/core/sbog_offset_pipe.sv -----
// ----------------------------------------------------------------------------
// sbog_offset_pipe
// three-stage offset datapath: index capture, stride products, sum
// ----------------------------------------------------------------------------
module sbog_offset_pipe #(
    parameter int MAX_DIMS = sbog_pkg::MAX_DIMS_DEFAULT
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [MAX_DIMS-1:0][sbog_pkg::IDX_W-1:0]     in_idx,
    input  sbog_pkg::sbog_flags_t                        in_flags,
    input  logic [MAX_DIMS-1:0][sbog_pkg::STRIDE_W-1:0]  dim_stride,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [sbog_pkg::OFFSET_W-1:0]                out_offset,
    output sbog_pkg::sbog_flags_t                        out_flags
);

    logic                                      v1_reg;
    logic                                      v2_reg;
    logic                                      v3_reg;
    logic                                      rdy1;
    logic                                      rdy2;
    logic                                      rdy3;
    logic [MAX_DIMS-1:0][sbog_pkg::IDX_W-1:0]  idx1_reg;
    logic [MAX_DIMS-1:0][sbog_pkg::PROD_W-1:0] prod2_reg;
    logic [sbog_pkg::OFFSET_W-1:0]             offset3_reg;
    logic [sbog_pkg::OFFSET_W-1:0]             sum_next;
    sbog_pkg::sbog_flags_t                     flags1_reg;
    sbog_pkg::sbog_flags_t                     flags2_reg;
    sbog_pkg::sbog_flags_t                     flags3_reg;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            sum_next = sum_next + sbog_pkg::OFFSET_W'(prod2_reg[d]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            idx1_reg   <= in_idx;
            flags1_reg <= in_flags;
        end
        if (rdy2 && v1_reg)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                prod2_reg[d] <= sbog_pkg::PROD_W'(dim_stride[d]) *
                                sbog_pkg::PROD_W'(idx1_reg[d]);
            end
            flags2_reg <= flags1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            offset3_reg <= sum_next;
            flags3_reg  <= flags2_reg;
        end
    end

    assign out_valid  = v3_reg;
    assign out_offset = offset3_reg;
    assign out_flags  = flags3_reg;

endmodule

// ----- rtl/core/strided_batch_offset_generator.sv -----
// ----------------------------------------------------------------------------
// strided_batch_offset_generator
// batch offset generator: one linear offset per request, odometer stepping
//
// channel   ports                          beat contents (low bit first)
// input     s_tvalid s_tready s_tdata      tdata: restart
// output    m_tvalid m_tready m_tdata      tdata: linear_offset
//           m_tlast m_tuser                tlast: is_last, tuser: is_empty
// config    cfg_we cfg_index cfg_data      one register per write, no wait
//
// one beat per cycle unless m_tready stalls the pipe; the result is registered
// through index capture, stride multiply and sum; odometer steps at acceptance
// reset clears positions and pipeline, registers take their defaults
// m_tready low holds all three stages; s_tready drops once they are full
// ----------------------------------------------------------------------------
module strided_batch_offset_generator #(
    parameter int MAX_DIMS = sbog_pkg::MAX_DIMS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sbog_pkg::S_TDATA_W-1:0]    s_tdata,   // restart
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sbog_pkg::M_TDATA_W-1:0]    m_tdata,   // linear_offset
    output logic                              m_tlast,
    output logic [0:0]                        m_tuser,   // is_empty
    input  logic                              cfg_we,
    input  logic [sbog_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbog_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [sbog_pkg::DCNT_W-1:0]                 dim_count;
    logic [sbog_pkg::OPK_W-1:0]                  op_kind;
    logic [MAX_DIMS-1:0][sbog_pkg::SIZE_W-1:0]   dim_size;
    logic [MAX_DIMS-1:0][sbog_pkg::STRIDE_W-1:0] dim_stride;
    logic [MAX_DIMS-1:0][sbog_pkg::IDX_W-1:0]    idx;
    sbog_pkg::sbog_flags_t                       flags;
    sbog_pkg::sbog_flags_t                       out_flags;
    logic [sbog_pkg::OFFSET_W-1:0]               out_offset;
    logic                                        pipe_ready;
    logic                                        accept;

    assign s_tready = pipe_ready;
    assign accept   = s_tvalid && pipe_ready;

    sbog_cfg_regs #(
        .MAX_DIMS (MAX_DIMS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .dim_count  (dim_count),
        .op_kind    (op_kind),
        .dim_size   (dim_size),
        .dim_stride (dim_stride)
    );

    sbog_odometer #(
        .MAX_DIMS (MAX_DIMS)
    ) u_odo (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (accept),
        .restart   (s_tdata[0]),
        .dim_count (dim_count),
        .op_kind   (op_kind),
        .dim_size  (dim_size),
        .idx       (idx),
        .flags     (flags)
    );

    sbog_offset_pipe #(
        .MAX_DIMS (MAX_DIMS)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (pipe_ready),
        .in_idx     (idx),
        .in_flags   (flags),
        .dim_stride (dim_stride),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_offset (out_offset),
        .out_flags  (out_flags)
    );

    assign m_tdata    = sbog_pkg::M_TDATA_W'(out_offset);
    assign m_tlast    = out_flags.last;
    assign m_tuser[0] = out_flags.empty;

endmodule
